// ----- hdl/gda_pkg.sv -----
// ============================================================================
// gda_pkg: shared types, constants and functions of the date adder
// Field widths, the microcode step codes, the control word layout and the
// calendar helpers used by the datapath, and the sequencer's program store.
// ============================================================================
package gda_pkg;

    // Field widths of the request and the result.
    localparam int YEAR_W       = 14;
    localparam int MON_W        = 4;
    localparam int DAY_W        = 5;
    localparam int LEN_W        = 5;
    localparam int ADD_BITS_DEF = 16;

    // Month codes that the calendar rules single out.
    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // Month lengths.
    localparam logic [LEN_W-1:0] LEN_28 = 5'd28;
    localparam logic [LEN_W-1:0] LEN_29 = 5'd29;
    localparam logic [LEN_W-1:0] LEN_30 = 5'd30;
    localparam logic [LEN_W-1:0] LEN_31 = 5'd31;

    // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
    // modulo 2^14 and compare against (2^14 - 1) / 25.
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    // Microcode step addresses.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step ST_IDLE  = 3'd0;
    localparam t_step ST_LEAP  = 3'd1;
    localparam t_step ST_DOY   = 3'd2;
    localparam t_step ST_ADD   = 3'd3;
    localparam t_step ST_WALK  = 3'd4;
    localparam t_step ST_NEWYR = 3'd5;
    localparam t_step ST_DONE  = 3'd6;

    // Branch conditions that a control word can test.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_DOY_MORE,
        C_WALK_OVER,
        C_OUT_FREE
    } t_cond;

    // Datapath operations, executed when the tested condition holds.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_LEAP,
        OP_DOY,
        OP_ADD,
        OP_WALK,
        OP_OUT
    } t_op;

    // One control word of the program.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  rdy;
        logic  wrap_en;
        t_step jmp_t;
        t_step jmp_f;
        t_step jmp_y;
    } t_uword;

    // Decoded strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic leap_upd;
        logic doy_step;
        logic add_days;
        logic walk_step;
        logic out_load;
    } t_ctl;

    // Status flags from the datapath back to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic doy_more;
        logic walk_over;
        logic year_end;
        logic out_free;
    } t_stat;

    // Gregorian leap rule: divisible by 4, and not by 100 unless by 400.
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = year * INV25;
        div25 = (prod <= DIV25_LIM);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // Length of a month; codes past December count as 31 days.
    function automatic logic [LEN_W-1:0] f_month_len(input logic [MON_W-1:0] mon,
                                                     input logic leap);
        logic [LEN_W-1:0] len;
        case (mon) inside
            MON_FEB:                          len = leap ? LEN_29 : LEN_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            default:                          len = LEN_31;
        endcase
        return len;
    endfunction

    // Program store of the sequencer.
    function automatic t_uword f_ucode(input t_step step);
        t_uword w;
        w = '{op: OP_NONE, cond: C_ALWAYS, rdy: 1'b0, wrap_en: 1'b0,
              jmp_t: ST_IDLE, jmp_f: ST_IDLE, jmp_y: ST_IDLE};
        unique case (step)
            ST_IDLE: begin
                w.op = OP_LOAD;  w.cond = C_IN_VALID; w.rdy = 1'b1;
                w.jmp_t = ST_LEAP; w.jmp_f = ST_IDLE;
            end
            ST_LEAP: begin
                w.op = OP_LEAP;  w.jmp_t = ST_DOY;
            end
            ST_DOY: begin
                w.op = OP_DOY;   w.cond = C_DOY_MORE;
                w.jmp_t = ST_DOY;  w.jmp_f = ST_ADD;
            end
            ST_ADD: begin
                w.op = OP_ADD;   w.jmp_t = ST_WALK;
            end
            ST_WALK: begin
                w.op = OP_WALK;  w.cond = C_WALK_OVER; w.wrap_en = 1'b1;
                w.jmp_t = ST_WALK; w.jmp_f = ST_DONE; w.jmp_y = ST_NEWYR;
            end
            ST_NEWYR: begin
                w.op = OP_LEAP;  w.jmp_t = ST_WALK;
            end
            ST_DONE: begin
                w.op = OP_OUT;   w.cond = C_OUT_FREE;
                w.jmp_t = ST_IDLE; w.jmp_f = ST_DONE;
            end
            default: begin
                w.jmp_t = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/gda_in_if.sv -----
// ============================================================================
// gda_in_if: request channel of the date adder
// Valid/ready handshake carrying the starting date and the days to add.
// ============================================================================
interface gda_in_if #(
    parameter int ADD_BITS = gda_pkg::ADD_BITS_DEF
);
    import gda_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   start_year;
    logic [MON_W-1:0]    start_month;
    logic [DAY_W-1:0]    start_day;
    logic [ADD_BITS-1:0] days_to_add;

    modport source (
        output valid, start_year, start_month, start_day, days_to_add,
        input  ready
    );

    modport sink (
        input  valid, start_year, start_month, start_day, days_to_add,
        output ready
    );
endinterface

// ----- hdl/gda_out_if.sv -----
// ============================================================================
// gda_out_if: result channel of the date adder
// Valid/ready handshake carrying the resulting date.
// ============================================================================
interface gda_out_if;
    import gda_pkg::*;

    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] result_year;
    logic [MON_W-1:0]  result_month;
    logic [DAY_W-1:0]  result_day;

    modport source (
        output valid, result_year, result_month, result_day,
        input  ready
    );

    modport sink (
        input  valid, result_year, result_month, result_day,
        output ready
    );
endinterface

// ----- hdl/gregorian_date_add_days_core.sv -----
// ============================================================================
// gregorian_date_add_days_core: adds a count of days to a Gregorian date
// Top level: request and result channels around the sequencer and datapath.
// ============================================================================
// The block takes one request at a time and gives one result for it. A small
// microcoded sequencer drives the datapath one operation per cycle unless it
// waits on a handshake: it loads the request, sums the lengths of the months
// before the start month, adds the days, then walks forward one month per
// cycle, with a leap update step after each year crossed, until the remainder
// fits in the current month. The month walk of the single remainder subtractor
// sets the run time of a request. The result sits in an output register, so a
// new request is taken while the previous result waits.
module gregorian_date_add_days_core #(
    parameter int ADD_BITS = gda_pkg::ADD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gda_in_if.sink     i_req,
    gda_out_if.source  o_res
);
    import gda_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    // Request handshake is opened by the sequencer's idle step.
    assign i_req.ready = w_ctl.in_ready;

    gda_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    gda_datapath #(
        .ADD_BITS (ADD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_in_valid     (i_req.valid),
        .i_start_year   (i_req.start_year),
        .i_start_month  (i_req.start_month),
        .i_start_day    (i_req.start_day),
        .i_days_to_add  (i_req.days_to_add),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_result_year  (o_res.result_year),
        .o_result_month (o_res.result_month),
        .o_result_day   (o_res.result_day)
    );

endmodule

// ----- hdl/gda_useq.sv -----
// ============================================================================
// gda_useq: microcode sequencer of the date adder
// Step counter, program store lookup, condition test and strobe decode.
// ============================================================================
module gda_useq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gda_pkg::t_stat i_stat,
    output gda_pkg::t_ctl  o_ctl
);
    import gda_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_cond_true;

    // Fetch the control word of the current step.
    assign w_word = f_ucode(r_step);

    // Evaluate the branch condition selected by the word.
    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:    w_cond_true = 1'b1;
            C_IN_VALID:  w_cond_true = i_stat.in_valid;
            C_DOY_MORE:  w_cond_true = i_stat.doy_more;
            C_WALK_OVER: w_cond_true = i_stat.walk_over;
            C_OUT_FREE:  w_cond_true = i_stat.out_free;
            default:     w_cond_true = 1'b0;
        endcase
    end

    // Next step: taken, year-wrap or fall-through target.
    always_comb begin
        if (!w_cond_true) begin
            n_step = w_word.jmp_f;
        end else if (w_word.wrap_en && i_stat.year_end) begin
            n_step = w_word.jmp_y;
        end else begin
            n_step = w_word.jmp_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Decode the operation into datapath strobes, gated by the condition.
    always_comb begin
        o_ctl          = '0;
        o_ctl.in_ready = w_word.rdy;
        unique case (w_word.op)
            OP_NONE: ;
            OP_LOAD: o_ctl.load      = w_cond_true;
            OP_LEAP: o_ctl.leap_upd  = w_cond_true;
            OP_DOY:  o_ctl.doy_step  = w_cond_true;
            OP_ADD:  o_ctl.add_days  = w_cond_true;
            OP_WALK: o_ctl.walk_step = w_cond_true;
            OP_OUT:  o_ctl.out_load  = w_cond_true;
            default: ;
        endcase
    end

endmodule

// ----- hdl/gda_datapath.sv -----
// ============================================================================
// gda_datapath: working registers and result register of the date adder
// Holds year, month counter, day remainder and leap flag, and applies the
// strobes from the sequencer one operation per cycle.
// ============================================================================
module gda_datapath #(
    parameter int ADD_BITS = gda_pkg::ADD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gda_pkg::t_ctl             i_ctl,
    output gda_pkg::t_stat            o_stat,
    input  logic                      i_in_valid,
    input  logic [gda_pkg::YEAR_W-1:0] i_start_year,
    input  logic [gda_pkg::MON_W-1:0]  i_start_month,
    input  logic [gda_pkg::DAY_W-1:0]  i_start_day,
    input  logic [ADD_BITS-1:0]        i_days_to_add,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [gda_pkg::YEAR_W-1:0] o_result_year,
    output logic [gda_pkg::MON_W-1:0]  o_result_month,
    output logic [gda_pkg::DAY_W-1:0]  o_result_day
);
    import gda_pkg::*;

    // Day of year plus the addend stays below 2^(ADD_BITS+2).
    localparam int REM_W = ADD_BITS + 2;

    logic [YEAR_W-1:0]   r_year,  n_year;
    logic [MON_W-1:0]    r_smon,  n_smon;
    logic [MON_W-1:0]    r_mon,   n_mon;
    logic [REM_W-1:0]    r_rem,   n_rem;
    logic [ADD_BITS-1:0] r_add,   n_add;
    logic                r_leap,  n_leap;
    logic [YEAR_W-1:0]   r_oyear;
    logic [MON_W-1:0]    r_omon;
    logic [DAY_W-1:0]    r_oday;
    logic                r_ovalid, n_ovalid;
    logic [LEN_W-1:0]    w_len;
    logic [REM_W-1:0]    w_len_ext;

    // Length of the month under the counter, for the current year.
    assign w_len     = f_month_len(r_mon, r_leap);
    assign w_len_ext = REM_W'(w_len);

    // Status back to the sequencer.
    always_comb begin
        o_stat.in_valid  = i_in_valid;
        o_stat.doy_more  = (r_mon < r_smon);
        o_stat.walk_over = (r_rem > w_len_ext);
        o_stat.year_end  = (r_mon == MON_DEC);
        o_stat.out_free  = !r_ovalid || i_out_ready;
    end

    // Next values of the working registers.
    always_comb begin
        n_year = r_year;
        n_smon = r_smon;
        n_mon  = r_mon;
        n_rem  = r_rem;
        n_add  = r_add;
        n_leap = r_leap;
        if (i_ctl.load) begin
            n_year = i_start_year;
            n_smon = i_start_month;
            n_mon  = MON_JAN;
            n_rem  = REM_W'(i_start_day);
            n_add  = i_days_to_add;
        end
        if (i_ctl.leap_upd) begin
            n_leap = f_is_leap(r_year);
        end
        if (i_ctl.doy_step) begin
            n_rem = r_rem + w_len_ext;
            n_mon = r_mon + 1'b1;
        end
        if (i_ctl.add_days) begin
            n_rem = r_rem + REM_W'(r_add);
            n_mon = MON_JAN;
        end
        if (i_ctl.walk_step) begin
            n_rem = r_rem - w_len_ext;
            if (r_mon == MON_DEC) begin
                n_mon  = MON_JAN;
                n_year = r_year + 1'b1;
            end else begin
                n_mon  = r_mon + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year <= n_year;
        r_smon <= n_smon;
        r_mon  <= n_mon;
        r_rem  <= n_rem;
        r_add  <= n_add;
        r_leap <= n_leap;
    end

    // Result register: filled when the walk ends, freed when taken.
    always_comb begin
        n_ovalid = r_ovalid;
        if (i_ctl.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_oyear <= r_year;
            r_omon  <= r_mon;
            r_oday  <= r_rem[DAY_W-1:0];
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_year  = r_oyear;
    assign o_result_month = r_omon;
    assign o_result_day   = r_oday;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench of the Gregorian date adder
// Sends starting dates with a count of days to add, predicts each resulting
// date with an independent calendar walk, and compares every result field by
// field. Both channels idle and stall at random, with some stretches run at
// full rate.
// ============================================================================
module tb;
    import gda_pkg::*;

    localparam int ADD_BITS     = ADD_BITS_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_ITEMS = 218;
    localparam int STEADY_ITEMS = 30;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } date_t;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    bit    steady;
    int    fail_count;
    int    cycle_count;
    date_t pending_dates[$];

    gda_in_if #(.ADD_BITS(ADD_BITS)) req_if();
    gda_out_if                       res_if();

    gregorian_date_add_days_core #(.ADD_BITS(ADD_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Clock and a cycle budget that stops a hung run.
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Leap rule: every 400th year is leap, other centuries are not.
    function automatic bit leap_year(input int unsigned yr);
        if (yr % 400 == 0) return 1'b1;
        if (yr % 100 == 0) return 1'b0;
        return (yr % 4) == 0;
    endfunction

    // Month codes above December fall through to 31 days.
    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input int unsigned mo);
        if (mo == 2) return leap_year(yr) ? 29 : 28;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
        return 31;
    endfunction

    // Resulting date: day of year plus the added days, then a month walk
    // from January of the start year with a 14-bit wrapping year.
    function automatic date_t shift_date(input logic [YEAR_W-1:0]   y,
                                         input logic [MON_W-1:0]    m,
                                         input logic [DAY_W-1:0]    d,
                                         input logic [ADD_BITS-1:0] add);
        int unsigned yr;
        int unsigned mo;
        int unsigned rem;
        date_t       res;
        yr  = 32'(y);
        rem = 32'(d);
        for (mo = 1; mo < 32'(m); mo++) rem += days_in_month(yr, mo);
        rem += 32'(add);
        mo = 1;
        while (rem > days_in_month(yr, mo)) begin
            rem -= days_in_month(yr, mo);
            mo++;
            if (mo > 12) begin
                mo = 1;
                yr = (yr + 1) % (1 << YEAR_W);
            end
        end
        res.year  = yr[YEAR_W-1:0];
        res.month = mo[MON_W-1:0];
        res.day   = rem[DAY_W-1:0];
        return res;
    endfunction

    // Result check against the oldest prediction, then prediction of each
    // request taken at this edge.
    always @(posedge i_clk) begin : scoreboard
        date_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_dates.size() == 0) begin
                $error("result %0d-%0d-%0d with no request outstanding",
                       res_if.result_year, res_if.result_month, res_if.result_day);
                fail_count++;
            end else begin
                want = pending_dates.pop_front();
                if (res_if.result_year !== want.year) begin
                    $error("result_year: expected %0d, got %0d",
                           want.year, res_if.result_year);
                    fail_count++;
                end
                if (res_if.result_month !== want.month) begin
                    $error("result_month: expected %0d, got %0d",
                           want.month, res_if.result_month);
                    fail_count++;
                end
                if (res_if.result_day !== want.day) begin
                    $error("result_day: expected %0d, got %0d",
                           want.day, res_if.result_day);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            pending_dates.push_back(shift_date(req_if.start_year, req_if.start_month,
                                               req_if.start_day, req_if.days_to_add));
        end
    end

    // Result side: a random stall before each result unless running steady.
    initial begin : result_sink
        int unsigned stall;
        res_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // Sends one request after a random gap, none when running steady, and waits until it is taken.
    task automatic send_request(input int unsigned y,
                                input int unsigned m,
                                input int unsigned d,
                                input int unsigned add);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.start_year  <= y[YEAR_W-1:0];
        req_if.start_month <= m[MON_W-1:0];
        req_if.start_day   <= d[DAY_W-1:0];
        req_if.days_to_add <= add[ADD_BITS-1:0];
        req_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Well-formed date in the given year range with a mix of add sizes.
    task automatic send_valid_date(input int unsigned year_lo, input int unsigned year_hi);
        int unsigned yr;
        int unsigned mo;
        int unsigned add;
        yr = $urandom_range(year_lo, year_hi);
        mo = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: add = $urandom_range(0, 65535);
            1: add = $urandom_range(0, 400);
            2: add = $urandom_range(0, 4000);
            default: add = $urandom_range(65000, 65535);
        endcase
        send_request(yr, mo, $urandom_range(1, days_in_month(yr, mo)), add);
    endtask

    // Month ends, leap years and century rules, and the largest additions.
    task automatic test_calendar_rules();
        send_request(2024, 1, 1, 0);
        send_request(2023, 12, 31, 1);
        send_request(2024, 2, 28, 1);
        send_request(2023, 2, 28, 1);
        send_request(1900, 2, 28, 1);
        send_request(2000, 2, 28, 1);
        send_request(2023, 4, 30, 1);
        send_request(2024, 3, 15, 365);
        send_request(1, 1, 1, 65535);
        send_request(9999, 12, 31, 65535);
    endtask

    // Field values outside a real calendar date, and year wrap-around.
    task automatic test_odd_fields();
        send_request(0, 2, 28, 1);        // year zero is leap
        send_request(2024, 0, 10, 0);     // month zero adds no months
        send_request(2024, 13, 1, 0);     // months past December count 31 days
        send_request(2023, 14, 5, 0);
        send_request(2024, 15, 31, 100);
        send_request(2024, 1, 0, 0);      // day zero stays zero in January
        send_request(2023, 4, 31, 0);     // excess days roll forward
        send_request(2023, 2, 31, 0);
        send_request(16383, 12, 31, 1);   // year counter wraps to zero
        send_request(16380, 6, 1, 65535);
        send_request(16383, 15, 31, 65535);
        send_request(0, 0, 0, 0);
    endtask

    // Back-to-back requests and results with no idling on either side.
    task automatic test_full_rate();
        steady = 1'b1;
        repeat (STEADY_ITEMS) begin
            send_request($urandom_range(1, 9999), $urandom_range(1, 12),
                         $urandom_range(1, 28), $urandom_range(0, 200));
        end
        steady = 1'b0;
    endtask

    // Mostly real dates, some near the year wrap, some with any field value.
    task automatic test_random_dates();
        int unsigned pick;
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_valid_date(1, 9999);
            end else if (pick < 75) begin
                send_valid_date(16200, 16383);
            end else begin
                send_request($urandom_range(0, 16383), $urandom_range(0, 15),
                             $urandom_range(0, 31), $urandom_range(0, 65535));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        steady             = 1'b0;
        fail_count         = 0;
        cycle_count        = 0;
        req_if.valid       = 1'b0;
        req_if.start_year  = '0;
        req_if.start_month = '0;
        req_if.start_day   = '0;
        req_if.days_to_add = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_rules();
        test_odd_fields();
        test_full_rate();
        test_random_dates();
        req_if.valid <= 1'b0;

        // Drain the outstanding results, then watch for stray ones.
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_dates.size() != 0) begin
            $error("%0d results never arrived", pending_dates.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
